### sv/rv32alu_pkg.sv
package rv32alu_pkg;

    localparam int XLEN       = 32;
    localparam int INSTR_W    = 32;
    localparam int REG_ADDR_W = 5;
    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);

    localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef struct packed {
        logic                  en;
        logic [REG_ADDR_W-1:0] idx;
        logic [XLEN-1:0]       data;
    } rf_write_t;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            ok;
    } alu_result_t;

    function automatic logic reg_in_range(input logic [REG_ADDR_W-1:0] idx);
        return (int'(idx) < REG_COUNT);
    endfunction

endpackage

### sv/rv32alu_regfile.sv
module rv32alu_regfile
    import rv32alu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [REG_ADDR_W-1:0] rs1,
    input  logic [REG_ADDR_W-1:0] rs2,
    input  rf_write_t             wr,
    output logic [XLEN-1:0]       a,
    output logic [XLEN-1:0]       b
);

    logic [XLEN-1:0]      mem_reg [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    logic [XLEN-1:0] a_data_reg;
    logic [XLEN-1:0] b_data_reg;
    logic            a_ok_reg;
    logic            b_ok_reg;
    logic            a_hit_reg;
    logic            b_hit_reg;
    logic [XLEN-1:0] byp_data_reg;

    // entries not yet written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx[REG_IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.idx[REG_IDX_W-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            a_data_reg   <= mem_reg[rs1[REG_IDX_W-1:0]];
            b_data_reg   <= mem_reg[rs2[REG_IDX_W-1:0]];
            a_ok_reg     <= reg_in_range(rs1) && valid_reg[rs1[REG_IDX_W-1:0]];
            b_ok_reg     <= reg_in_range(rs2) && valid_reg[rs2[REG_IDX_W-1:0]];
            a_hit_reg    <= wr.en && (wr.idx == rs1);
            b_hit_reg    <= wr.en && (wr.idx == rs2);
            byp_data_reg <= wr.data;
        end
    end

    // write in the same cycle as the read wins
    assign a = a_hit_reg ? byp_data_reg : (a_ok_reg ? a_data_reg : '0);
    assign b = b_hit_reg ? byp_data_reg : (b_ok_reg ? b_data_reg : '0);

endmodule

### sv/rv32alu_exec.sv
module rv32alu_exec
    import rv32alu_pkg::*;
(
    input  logic [INSTR_W-1:0] instruction,
    input  logic [XLEN-1:0]    a,
    input  logic [XLEN-1:0]    b,
    output alu_result_t        result
);

    logic [6:0]      opcode;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] op2;
    logic [4:0]      shamt;

    assign opcode = instruction[6:0];
    assign f3     = instruction[14:12];
    assign f7     = instruction[31:25];
    assign imm    = {{20{instruction[31]}}, instruction[31:20]};
    assign op2    = (opcode == OPC_OP) ? b : imm;
    assign shamt  = op2[4:0];

    always_comb
    begin
        result.value = '0;
        result.ok    = 1'b1;
        unique case (opcode)
            OPC_OP_IMM, OPC_OP:
            begin
                unique case (f3)
                    F3_ADD:
                    begin
                        if (opcode == OPC_OP_IMM || f7 == F7_BASE)
                            result.value = a + op2;
                        else if (f7 == F7_ALT)
                            result.value = a - op2;
                        else
                            result.ok = 1'b0;
                    end
                    F3_SLL:
                    begin
                        result.value = a << shamt;
                        if (opcode == OPC_OP_IMM && f7 != F7_BASE)
                            result.ok = 1'b0;
                    end
                    F3_SLT:  result.value = {31'd0, $signed(a) < $signed(op2)};
                    F3_SLTU: result.value = {31'd0, a < op2};
                    F3_XOR:  result.value = a ^ op2;
                    F3_SR:
                    begin
                        if (f7 == F7_BASE)
                            result.value = a >> shamt;
                        else if (f7 == F7_ALT)
                            result.value = XLEN'($signed(a) >>> shamt);
                        else
                            result.ok = 1'b0;
                    end
                    F3_OR:   result.value = a | op2;
                    F3_AND:  result.value = a & op2;
                    default: result.ok = 1'b0;
                endcase
            end
            OPC_LUI: result.value = {instruction[31:12], 12'd0};
            default: result.ok = 1'b0;
        endcase
    end

endmodule

### sv/rv32i_alu_instruction_executor_core.sv
// rv32i integer alu instruction executor
// request channel: instruction with instr_valid / instr_stall. a request is
// taken at a rising edge with instr_valid high and instr_stall low.
// result channel: dest_index, write_value, wrote, next_pc and unsupported with
// result_valid / result_stall, taken the same way.
// a taken request waits in the input register, its operands read from the
// register file when it is taken, and moves to the result register when it advances.
// the register file is written when the result is registered, with a bypass for a
// back-to-back dependency, so one request per cycle is sustained while result_stall is low.
// reset clears the register file (per-entry valid bits), the program counter
// and both valid flags at once; no clearing pass is needed.
// while result_stall is high the result holds; one further request may wait
// in the input register, after which instr_stall goes high until the result
// is taken.
module rv32i_alu_instruction_executor_core
    import rv32alu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  instr_valid,
    output logic                  instr_stall,
    input  logic [INSTR_W-1:0]    instruction,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [REG_ADDR_W-1:0] dest_index,
    output logic [XLEN-1:0]       write_value,
    output logic                  wrote,
    output logic [XLEN-1:0]       next_pc,
    output logic                  unsupported
);

    logic                  instr_valid_reg;
    logic [INSTR_W-1:0]    instr_reg;
    logic [XLEN-1:0]       pc_reg;
    logic [XLEN-1:0]       pc_next;
    logic                  result_valid_reg;
    logic [REG_ADDR_W-1:0] dest_reg;
    logic [XLEN-1:0]       value_reg;
    logic                  wrote_reg;
    logic                  wrote_next;
    logic [XLEN-1:0]       next_pc_reg;
    logic                  unsupported_reg;

    logic                  advance;
    logic                  accept;
    logic [REG_ADDR_W-1:0] rd;
    logic [XLEN-1:0]       a;
    logic [XLEN-1:0]       b;
    alu_result_t           alu;
    rf_write_t             wr;

    assign advance     = instr_valid_reg && (!result_valid_reg || !result_stall);
    assign instr_stall = instr_valid_reg && !advance;
    assign accept      = instr_valid && !instr_stall;

    assign rd         = instr_reg[11:7];
    assign wrote_next = alu.ok && (rd != '0) && reg_in_range(rd);
    assign pc_next    = pc_reg + PC_STEP;

    assign wr.en   = advance && wrote_next;
    assign wr.idx  = rd;
    assign wr.data = alu.value;

    rv32alu_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .rs1   (instruction[19:15]),
        .rs2   (instruction[24:20]),
        .wr    (wr),
        .a     (a),
        .b     (b)
    );

    rv32alu_exec u_exec (
        .instruction (instr_reg),
        .a           (a),
        .b           (b),
        .result      (alu)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instr_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            pc_reg           <= '0;
        end
        else
        begin
            if (accept)
                instr_valid_reg <= 1'b1;
            else if (advance)
                instr_valid_reg <= 1'b0;

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                pc_reg           <= pc_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= instruction;
        end
        if (advance)
        begin
            dest_reg        <= rd;
            value_reg       <= wrote_next ? alu.value : '0;
            wrote_reg       <= wrote_next;
            next_pc_reg     <= pc_next;
            unsupported_reg <= !alu.ok;
        end
    end

    assign result_valid = result_valid_reg;
    assign dest_index   = dest_reg;
    assign write_value  = value_reg;
    assign wrote        = wrote_reg;
    assign next_pc      = next_pc_reg;
    assign unsupported  = unsupported_reg;

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("pending request did not reach the result register");

    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (next_pc == $past(pc_reg) + PC_STEP) && (pc_reg == next_pc))
        else $error("program counter did not step by four");

    a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && wrote |-> !unsupported && (dest_index != '0))
        else $error("write flagged for x0 or an unsupported request");

    a_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !wrote |-> (write_value == '0))
        else $error("write value not zero without a write");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid_reg && !advance |=> instr_valid_reg && $stable(instr_reg))
        else $error("waiting request lost or overwritten");

endmodule
